### rtl/ps2a_pkg.sv
// ----------------------------------------------------------------------------
// ps2a_pkg
// Shared types, codes and translation tables for the PS/2 set-2 decoder.
// ----------------------------------------------------------------------------
package ps2a_pkg;

   // Default size of the key map
   localparam int KEY_CODES_DEFAULT = 256;

   // Prefix bytes of the set-2 protocol
   localparam logic [7:0] PFX_EXT   = 8'hE0;
   localparam logic [7:0] PFX_BREAK = 8'hF0;
   localparam logic [7:0] PFX_PAUSE = 8'hE1;

   // Extended keys that translate to a character
   localparam logic [7:0] EXT_KP_SLASH = 8'h4A;
   localparam logic [7:0] EXT_KP_ENTER = 8'h5A;
   localparam logic [7:0] CHR_SLASH    = 8'h2F;
   localparam logic [7:0] CHR_CR       = 8'h0D;

   // Letter case handling
   localparam logic [7:0] CASE_DIFF = 8'h20;
   localparam logic [7:0] CHR_UP_A  = 8'h41;
   localparam logic [7:0] CHR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHR_LO_A  = 8'h61;
   localparam logic [7:0] CHR_LO_Z  = 8'h7A;

   // Register reset values
   localparam logic [7:0] LEFT_SHIFT_RST  = 8'd18;
   localparam logic [7:0] RIGHT_SHIFT_RST = 8'd89;
   localparam logic [7:0] CAPS_LOCK_RST   = 8'd88;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_SHIFT  = 2'd0,
      CSR_RIGHT_SHIFT = 2'd1,
      CSR_CAPS_LOCK   = 2'd2
   } csr_idx_type;

   // Write port of the key map
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic       val;
   } map_wr_type;

   // One result beat
   typedef struct packed {
      logic [7:0] last_scan;
      logic [7:0] last_char;
      logic       paused;
      logic       caps_on;
      logic       shift_held;
      logic       key_pressed;
   } rsp_type;

   // Unshifted translation table
   localparam logic [7:0] PLAIN_TAB [128] = '{
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h09,8'h60,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h71,8'h31,8'h00,
      8'h00,8'h00,8'h7A,8'h73,8'h61,8'h77,8'h32,8'h00,
      8'h00,8'h63,8'h78,8'h64,8'h65,8'h34,8'h33,8'h00,
      8'h00,8'h20,8'h76,8'h66,8'h74,8'h72,8'h35,8'h00,
      8'h00,8'h6E,8'h62,8'h68,8'h67,8'h79,8'h36,8'h00,
      8'h00,8'h00,8'h6D,8'h6A,8'h75,8'h37,8'h38,8'h00,
      8'h00,8'h2C,8'h6B,8'h69,8'h6F,8'h30,8'h39,8'h00,
      8'h00,8'h2E,8'h2F,8'h6C,8'h3B,8'h70,8'h00,8'h00,
      8'h00,8'h00,8'h27,8'h00,8'h5B,8'h3D,8'h00,8'h00,
      8'h00,8'h00,8'h0D,8'h5D,8'h00,8'h5C,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h08,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1B,8'h00,
      8'h00,8'h2B,8'h00,8'h2D,8'h2A,8'h00,8'h00,8'h00
   };

   // Shifted translation table
   localparam logic [7:0] SHIFT_TAB [128] = '{
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h09,8'h7E,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h51,8'h21,8'h00,
      8'h00,8'h00,8'h5A,8'h53,8'h41,8'h57,8'h40,8'h00,
      8'h00,8'h43,8'h58,8'h44,8'h45,8'h24,8'h23,8'h00,
      8'h00,8'h20,8'h56,8'h46,8'h54,8'h52,8'h25,8'h00,
      8'h00,8'h4E,8'h42,8'h48,8'h47,8'h59,8'h5E,8'h00,
      8'h00,8'h00,8'h4D,8'h4A,8'h55,8'h26,8'h2A,8'h00,
      8'h00,8'h3C,8'h4B,8'h49,8'h4F,8'h29,8'h28,8'h00,
      8'h00,8'h3E,8'h3F,8'h4C,8'h3A,8'h50,8'h00,8'h00,
      8'h00,8'h00,8'h22,8'h00,8'h7B,8'h2B,8'h00,8'h00,
      8'h00,8'h00,8'h0D,8'h7D,8'h00,8'h7C,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h08,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1B,8'h00,
      8'h00,8'h2B,8'h00,8'h2D,8'h2A,8'h00,8'h00,8'h00
   };

endpackage

### rtl/ps2_scan_code_to_ascii.sv
// ----------------------------------------------------------------------------
// ps2_scan_code_to_ascii
// PS/2 set-2 keyboard byte decoder with pressed-key map and ASCII translation.
// ----------------------------------------------------------------------------
// Takes one keyboard byte per cycle while req_ready is high and returns one
// result beat per byte, registered through a two-entry output buffer
// (output register plus skid entry) so input keeps flowing while a result
// waits. The key map lives in a memory; the state of the two shift keys is
// mirrored in registers, so a byte needs no map read. After each register
// write the block holds req_ready low through its pending and load states
// while the map is read at the new shift codes to reload the mirrors. A
// clear item empties the map through per-entry valid flags; there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module ps2_scan_code_to_ascii #(
   parameter int KEY_CODES = ps2a_pkg::KEY_CODES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // byte input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [7:0]                    req_scan_byte,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_last_scan,
   output logic [7:0]                    rsp_last_char,
   output logic                          rsp_paused,
   output logic                          rsp_caps_on,
   output logic                          rsp_shift_held,
   output logic                          rsp_key_pressed,
   // register write port
   input  logic                          csr_write_en,
   input  logic [ps2a_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata
);

   localparam logic [8:0] KEY_LIMIT = 9'(KEY_CODES);

   // registers
   logic [7:0]        left_ff,  left_in;
   logic [7:0]        right_ff, right_in;
   logic [7:0]        caps_code_ff, caps_code_in;
   logic              ext_ff,   ext_in;
   logic              make_ff,  make_in;
   logic              caps_ff,  caps_in;
   logic              pause_ff, pause_in;
   logic [7:0]        scan_ff,  scan_in;
   logic [7:0]        char_ff,  char_in;
   logic              shl_ff,   shl_in;
   logic              shr_ff,   shr_in;
   logic              pend_ff,  pend_in;
   logic              load_ff,  load_in;
   logic              out_vld_ff, out_vld_in;
   logic              skid_vld_ff, skid_vld_in;
   ps2a_pkg::rsp_type out_ff,  out_in;
   ps2a_pkg::rsp_type skid_ff, skid_in;

   // combinational
   ps2a_pkg::map_wr_type map_wr;
   ps2a_pkg::rsp_type    rsp_new;
   logic                 accept;
   logic                 take;
   logic                 clear;
   logic                 is_key;
   logic                 in_rng;
   logic                 hit_l;
   logic                 hit_r;
   logic                 do_wr;
   logic                 rd_bit_a;
   logic                 rd_bit_b;
   logic [7:0]           ch;
   logic [7:0]           k;

   assign k         = req_scan_byte;
   assign req_ready = !pend_ff && !load_ff && !skid_vld_ff;
   assign accept    = req_valid && req_ready;
   assign take      = out_vld_ff && rsp_ready;
   assign clear     = accept && req_mode;

   ps2a_key_map #(
      .KEY_CODES (KEY_CODES)
   ) u_key_map (
      .clock     (clock),
      .reset     (reset),
      .wr        (map_wr),
      .clear     (clear),
      .rd_en     (pend_ff),
      .rd_addr_a (left_ff),
      .rd_addr_b (right_ff),
      .rd_bit_a  (rd_bit_a),
      .rd_bit_b  (rd_bit_b)
   );

   // Register writes; any write starts a reload of the shift mirrors
   always_comb begin
      left_in      = left_ff;
      right_in     = right_ff;
      caps_code_in = caps_code_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            ps2a_pkg::CSR_LEFT_SHIFT:  left_in      = csr_wdata;
            ps2a_pkg::CSR_RIGHT_SHIFT: right_in     = csr_wdata;
            ps2a_pkg::CSR_CAPS_LOCK:   caps_code_in = csr_wdata;
            default: ;
         endcase
      end
      pend_in = csr_write_en;
      load_in = pend_ff;
   end

   // Decode the byte, update the map, mirrors and flags, translate
   always_comb begin
      is_key = !(k == ps2a_pkg::PFX_EXT || k == ps2a_pkg::PFX_BREAK ||
                 k == ps2a_pkg::PFX_PAUSE);
      in_rng = {1'b0, k} < KEY_LIMIT;
      hit_l  = k == left_ff;
      hit_r  = k == right_ff;
      // break of an extended shift leaves the map alone
      do_wr  = make_ff || !ext_ff || !(hit_l || hit_r);

      map_wr.en   = accept && !req_mode && is_key && do_wr && in_rng;
      map_wr.addr = k;
      map_wr.val  = make_ff;

      ext_in   = ext_ff;
      make_in  = make_ff;
      caps_in  = caps_ff;
      pause_in = pause_ff;
      scan_in  = scan_ff;
      char_in  = char_ff;

      // shift mirrors
      shl_in = shl_ff;
      shr_in = shr_ff;
      if (load_ff) begin
         shl_in = rd_bit_a;
         shr_in = rd_bit_b;
      end else if (clear) begin
         shl_in = 1'b0;
         shr_in = 1'b0;
      end else if (map_wr.en) begin
         if (hit_l) shl_in = make_ff;
         if (hit_r) shr_in = make_ff;
      end

      if (accept && !req_mode && is_key && make_ff && !ext_ff &&
          k == caps_code_ff) begin
         caps_in = !caps_ff;
      end

      // translate
      ch = 8'h00;
      if (!k[7]) begin
         if (ext_ff) begin
            if (k == ps2a_pkg::EXT_KP_SLASH) ch = ps2a_pkg::CHR_SLASH;
            else if (k == ps2a_pkg::EXT_KP_ENTER) ch = ps2a_pkg::CHR_CR;
         end else if (shl_in || shr_in) begin
            ch = ps2a_pkg::SHIFT_TAB[k[6:0]];
            if (caps_in && ch >= ps2a_pkg::CHR_UP_A && ch <= ps2a_pkg::CHR_UP_Z) begin
               ch = ch + ps2a_pkg::CASE_DIFF;
            end
         end else begin
            ch = ps2a_pkg::PLAIN_TAB[k[6:0]];
            if (caps_in && ch >= ps2a_pkg::CHR_LO_A && ch <= ps2a_pkg::CHR_LO_Z) begin
               ch = ch - ps2a_pkg::CASE_DIFF;
            end
         end
      end

      // flags and recent code
      if (accept) begin
         if (req_mode) begin
            scan_in = 8'h00;
            char_in = 8'h00;
         end else if (k == ps2a_pkg::PFX_EXT) begin
            ext_in = 1'b1;
         end else if (k == ps2a_pkg::PFX_BREAK) begin
            make_in = 1'b0;
         end else if (k == ps2a_pkg::PFX_PAUSE) begin
            pause_in = 1'b1;
         end else begin
            if (make_ff) begin
               scan_in = k;
               if (ch != 8'h00) char_in = ch;
            end
            ext_in  = 1'b0;
            make_in = 1'b1;
         end
      end

      rsp_new.last_scan   = scan_in;
      rsp_new.last_char   = char_in;
      rsp_new.paused      = pause_in;
      rsp_new.caps_on     = caps_in;
      rsp_new.shift_held  = shl_in || shr_in;
      rsp_new.key_pressed = !req_mode && is_key && in_rng &&
                            (hit_l ? shl_in : (hit_r ? shr_in : make_ff));
   end

   // Output buffer: output register plus one skid entry
   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (!out_vld_ff || take) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = rsp_new;
            out_vld_in = accept;
         end
      end else if (accept) begin
         skid_in     = rsp_new;
         skid_vld_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= ps2a_pkg::LEFT_SHIFT_RST;
         right_ff     <= ps2a_pkg::RIGHT_SHIFT_RST;
         caps_code_ff <= ps2a_pkg::CAPS_LOCK_RST;
         ext_ff       <= 1'b0;
         make_ff      <= 1'b1;
         caps_ff      <= 1'b0;
         pause_ff     <= 1'b0;
         scan_ff      <= 8'h00;
         char_ff      <= 8'h00;
         shl_ff       <= 1'b0;
         shr_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         load_ff      <= 1'b0;
         out_vld_ff   <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else begin
         left_ff      <= left_in;
         right_ff     <= right_in;
         caps_code_ff <= caps_code_in;
         ext_ff       <= ext_in;
         make_ff      <= make_in;
         caps_ff      <= caps_in;
         pause_ff     <= pause_in;
         scan_ff      <= scan_in;
         char_ff      <= char_in;
         shl_ff       <= shl_in;
         shr_ff       <= shr_in;
         pend_ff      <= pend_in;
         load_ff      <= load_in;
         out_vld_ff   <= out_vld_in;
         skid_vld_ff  <= skid_vld_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_last_scan   = out_ff.last_scan;
   assign rsp_last_char   = out_ff.last_char;
   assign rsp_paused      = out_ff.paused;
   assign rsp_caps_on     = out_ff.caps_on;
   assign rsp_shift_held  = out_ff.shift_held;
   assign rsp_key_pressed = out_ff.key_pressed;

endmodule

### rtl/ps2a_key_map.sv
// ----------------------------------------------------------------------------
// ps2a_key_map
// Pressed-key map: one bit per scan code in a synchronous memory, with a
// per-entry valid flag so the whole map clears without a memory pass. Two
// registered read ports, one write port.
// ----------------------------------------------------------------------------
module ps2a_key_map #(
   parameter int KEY_CODES = ps2a_pkg::KEY_CODES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ps2a_pkg::map_wr_type wr,
   input  logic                 clear,
   input  logic                 rd_en,
   input  logic [7:0]           rd_addr_a,
   input  logic [7:0]           rd_addr_b,
   output logic                 rd_bit_a,
   output logic                 rd_bit_b
);

   localparam int         KEY_AW    = $clog2(KEY_CODES);
   localparam logic [8:0] KEY_LIMIT = 9'(KEY_CODES);

   logic                 mem [KEY_CODES];
   logic [KEY_CODES-1:0] valid_ff;
   logic                 wr_rng;
   logic                 a_rng;
   logic                 b_rng;
   logic                 rd_mem_a_ff;
   logic                 rd_mem_b_ff;
   logic                 rd_vld_a_ff;
   logic                 rd_vld_b_ff;

   assign wr_rng = {1'b0, wr.addr}   < KEY_LIMIT;
   assign a_rng  = {1'b0, rd_addr_a} < KEY_LIMIT;
   assign b_rng  = {1'b0, rd_addr_b} < KEY_LIMIT;

   // Valid flags: drop all on reset or clear, mark on write
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr.en && wr_rng) begin
         valid_ff[wr.addr[KEY_AW-1:0]] <= 1'b1;
      end
   end

   // Memory write
   always_ff @(posedge clock) begin
      if (wr.en && wr_rng) begin
         mem[wr.addr[KEY_AW-1:0]] <= wr.val;
      end
   end

   // Registered reads; codes outside the map read as released
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mem_a_ff <= mem[rd_addr_a[KEY_AW-1:0]];
         rd_mem_b_ff <= mem[rd_addr_b[KEY_AW-1:0]];
         rd_vld_a_ff <= valid_ff[rd_addr_a[KEY_AW-1:0]] & a_rng;
         rd_vld_b_ff <= valid_ff[rd_addr_b[KEY_AW-1:0]] & b_rng;
      end
   end

   assign rd_bit_a = rd_mem_a_ff & rd_vld_a_ff;
   assign rd_bit_b = rd_mem_b_ff & rd_vld_b_ff;

endmodule
